@@ rtl/ia2d_pkg.sv @@
// ia2d_pkg: shared types, constants and the digit-to-ASCII function for the
// integer to ASCII converter. No dependencies.
`timescale 1ns / 1ps

package ia2d_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } ia2d_state_type;

   // binary bits folded into the BCD digits per conversion step
   localparam int BITS_PER_STEP = 2;

   // shift-and-add-3 correction
   localparam logic [3:0] DABBLE_LIMIT = 4'd5;
   localparam logic [3:0] DABBLE_ADJ   = 4'd3;

   localparam logic [3:0] DEC_MAX      = 4'd9;
   localparam logic [3:0] DEC_BASE     = 4'd10;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   function automatic logic [7:0] digit_code(input logic [3:0] d, input logic up);
      logic [3:0] off;
      off = d - DEC_BASE;
      if (d <= DEC_MAX) begin
         digit_code = CHAR_ZERO + {4'd0, d};
      end else if (up) begin
         digit_code = CHAR_UPPER_A + {4'd0, off};
      end else begin
         digit_code = CHAR_LOWER_A + {4'd0, off};
      end
   endfunction

endpackage

@@ rtl/ia2d_bcd_step.sv @@
// ia2d_bcd_step: one step of the double-dabble binary to BCD unit, folding
// BITS_PER_STEP binary bits into the BCD digit vector. Uses ia2d_pkg.
`timescale 1ns / 1ps

module ia2d_bcd_step #(
   parameter int NDIG = 20
) (
   input  logic [NDIG-1:0][3:0]                digits_cur,
   input  logic [ia2d_pkg::BITS_PER_STEP-1:0]  bits_in,
   output logic [NDIG-1:0][3:0]                digits_next
);

   localparam int DW = NDIG * 4;

   logic [DW-1:0] work;

   always_comb begin
      work = digits_cur;
      for (int b = ia2d_pkg::BITS_PER_STEP - 1; b >= 0; b--) begin
         for (int d = 0; d < NDIG; d++) begin
            if (work[d*4 +: 4] >= ia2d_pkg::DABBLE_LIMIT) begin
               work[d*4 +: 4] = work[d*4 +: 4] + ia2d_pkg::DABBLE_ADJ;
            end
         end
         work = {work[DW-2:0], bits_in[b]};
      end
      digits_next = work;
   end

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// Sequence: a decimal request is accepted, then converted by MAX_WIDTH/2 (32 for 64 bits) or 16
// (narrow) double-dabble steps; leading zeros are skipped, then one character is emitted per
// cycle while the receiver is ready. Hex skips the conversion steps.
// Throughput: one request at a time; ready again once the last character sits in
// the output register. The conversion steps share one two-bit BCD step unit.
// Reset: synchronous; returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps

module integer_to_ascii_digits #(
   parameter int MAX_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   input  logic        req_wide,
   input  logic        req_hex,
   input  logic        req_upper,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);

   localparam int BITS         = ia2d_pkg::BITS_PER_STEP;
   localparam int MAGW         = MAX_WIDTH + (MAX_WIDTH % 2);
   localparam int NDIG         = (MAX_WIDTH * 30103) / 100000 + 1;
   localparam int NHEX         = (MAX_WIDTH + 3) / 4;
   localparam int NARROW_HEX   = 8;
   localparam int DW           = NDIG * 4;
   localparam int IDXW         = $clog2(NDIG);
   localparam int STEPS        = MAGW / BITS;
   localparam int CNTW         = $clog2(STEPS);
   localparam int NARROW_STEPS = 32 / BITS;
   localparam int NARROW_SHIFT = MAGW - 32;

   ia2d_pkg::ia2d_state_type state_ff, state_in;

   logic [MAGW-1:0]         mag_ff, mag_in;
   logic [NDIG-1:0][3:0]    digits_ff, digits_in, step_out;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [IDXW-1:0]         idx_ff, idx_in;
   logic                    sign_ff, sign_in;
   logic                    started_ff, started_in;
   logic                    upper_ff, upper_in;
   logic                    hex_ff, hex_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [31:0]             nar_val, nar_abs;
   logic [MAX_WIDTH-1:0]    wid_val, wid_abs;
   logic                    neg;
   logic [MAGW-1:0]         mag_raw;
   logic                    hex_sel;
   logic [3:0]              cur_digit;
   logic                    out_free;
   logic                    load_digit;

   // operand masking and wraparound magnitude
   always_comb begin
      nar_val = req_value[31:0];
      wid_val = req_value[MAX_WIDTH-1:0];
      nar_abs = ~nar_val + 1'b1;
      wid_abs = ~wid_val + 1'b1;
      if (req_wide) begin
         neg     = req_is_signed & wid_val[MAX_WIDTH-1];
         mag_raw = neg ? MAGW'(wid_abs) : MAGW'(wid_val);
      end else begin
         neg     = req_is_signed & nar_val[31];
         mag_raw = neg ? MAGW'(nar_abs) : MAGW'(nar_val);
      end
      hex_sel = req_hex & ~req_is_signed;
   end

   ia2d_bcd_step #(
      .NDIG (NDIG)
   ) u_step (
      .digits_cur  (digits_ff),
      .bits_in     (mag_ff[MAGW-1 -: BITS]),
      .digits_next (step_out)
   );

   assign cur_digit = digits_ff[idx_ff];
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sign_in      = sign_ff;
      started_in   = started_ff;
      upper_in     = upper_ff;
      hex_in       = hex_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      load_digit   = 1'b0;
      case (state_ff)
         ia2d_pkg::ST_IDLE: begin
            if (req_valid) begin
               sign_in    = neg;
               started_in = 1'b0;
               upper_in   = req_upper & ~req_is_signed;
               hex_in     = hex_sel;
               if (hex_sel) begin
                  // nibbles are already the digits
                  digits_in = DW'(mag_raw);
                  idx_in    = req_wide ? IDXW'(NHEX - 1) : IDXW'(NARROW_HEX - 1);
                  state_in  = ia2d_pkg::ST_EMIT;
               end else begin
                  digits_in = '0;
                  mag_in    = req_wide ? mag_raw : (mag_raw << NARROW_SHIFT);
                  cnt_in    = req_wide ? CNTW'(STEPS - 1) : CNTW'(NARROW_STEPS - 1);
                  idx_in    = IDXW'(NDIG - 1);
                  state_in  = ia2d_pkg::ST_CONV;
               end
            end
         end
         ia2d_pkg::ST_CONV: begin
            digits_in = step_out;
            mag_in    = mag_ff << BITS;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ia2d_pkg::ST_EMIT;
            end
         end
         ia2d_pkg::ST_EMIT: begin
            if (!started_ff && idx_ff != '0 && cur_digit == '0) begin
               // leading zero, drop it
               idx_in = idx_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = ia2d_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  load_digit  = 1'b1;
                  rsp_char_in = ia2d_pkg::digit_code(cur_digit, upper_ff);
                  rsp_last_in = (idx_ff == '0);
                  started_in  = 1'b1;
                  if (idx_ff == '0) begin
                     state_in = ia2d_pkg::ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ia2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ia2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      digits_ff   <= digits_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      sign_ff     <= sign_in;
      started_ff  <= started_in;
      upper_ff    <= upper_in;
      hex_ff      <= hex_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready    = (state_ff == ia2d_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   ap_conv_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ia2d_pkg::ST_CONV && cnt_ff == '0) |=> (state_ff == ia2d_pkg::ST_EMIT))
      else $error("conversion did not hand over to emit");

   ap_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == ia2d_pkg::CHAR_MINUS) |-> !rsp_last_ff)
      else $error("minus sign marked as last character");

   ap_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ia2d_pkg::ST_EMIT && !hex_ff) |-> (cur_digit <= ia2d_pkg::DEC_MAX))
      else $error("decimal digit out of range");

   ap_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (load_digit && !started_ff) |-> (cur_digit != '0 || idx_ff == '0))
      else $error("leading zero emitted");

endmodule

@@ sim/integer_to_ascii_digits_checker.sv @@
// Checker for integer_to_ascii_digits: watches both channels, predicts the character
// stream of each accepted request and compares every accepted character with it.
// Depends on ia2d_pkg for the ASCII character constants.
`timescale 1ns / 1ps

module integer_to_ascii_digits_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   input  logic        req_wide,
   input  logic        req_hex,
   input  logic        req_upper,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_char_out,
   input  logic        rsp_last,
   output int          fail_count,
   output int          chars_pending,
   output int          numbers_done,
   output int          chars_done
);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } ascii_char_type;

   ascii_char_type expected_chars[$];

   initial begin
      fail_count    = 0;
      chars_pending = 0;
      numbers_done  = 0;
      chars_done    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] char check: %s", $time, what);
      fail_count++;
   endtask

   // Queues the characters one request should produce, most significant first
   task automatic predict_characters(input logic [63:0] value, input logic is_signed,
                                     input logic wide, input logic hex, input logic upper);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [3:0]  digit;
      logic [7:0]  digs [0:19];
      logic        neg;
      int          nd;
      mag = wide ? value : {32'd0, value[31:0]};
      neg = is_signed && (wide ? value[63] : value[31]);
      if (neg) begin
         expected_chars.push_back(ascii_char_type'{code: ia2d_pkg::CHAR_MINUS,
                                                   last: 1'b0});
         // wraparound negation, so the most negative value maps onto itself
         mag = 64'd0 - mag;
         if (!wide) begin
            mag = {32'd0, mag[31:0]};
         end
      end
      radix = (!is_signed && hex) ? 64'd16 : 64'd10;
      nd = 0;
      do begin
         digit = 4'(mag % radix);
         if (digit < 4'd10) begin
            digs[nd] = ia2d_pkg::CHAR_ZERO + {4'd0, digit};
         end else begin
            digs[nd] = (upper ? ia2d_pkg::CHAR_UPPER_A : ia2d_pkg::CHAR_LOWER_A)
                       + {4'd0, digit} - 8'd10;
         end
         mag = mag / radix;
         nd++;
      end while (mag != 64'd0);
      for (int k = nd - 1; k >= 0; k--) begin
         expected_chars.push_back(ascii_char_type'{code: digs[k], last: (k == 0)});
      end
   endtask

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_characters(req_value, req_is_signed, req_wide, req_hex, req_upper);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                         rsp_char_out, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_out !== want.code) begin
                  report_mismatch($sformatf("number %0d: char 0x%02h, expected 0x%02h",
                                            numbers_done, rsp_char_out, want.code));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("number %0d: last %0b, expected %0b",
                                            numbers_done, rsp_last, want.last));
               end
            end
            chars_done++;
            if (rsp_last === 1'b1) begin
               numbers_done++;
            end
         end
         chars_pending = expected_chars.size();
      end
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for integer_to_ascii_digits: clock, reset, request stimulus with
// random idling on both sides, watchdog and verdict. Depends on the block and on
// integer_to_ascii_digits_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;

   localparam int CLK_PERIOD       = 8;
   localparam int RESET_CYCLES     = 5;
   localparam int RANDOM_PER_PHASE = 130;
   localparam int DRAIN_CYCLES     = 100;
   localparam int WATCHDOG_LIMIT   = 2000;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [63:0] req_value     = 64'd0;
   logic        req_is_signed = 1'b0;
   logic        req_wide      = 1'b0;
   logic        req_hex       = 1'b0;
   logic        req_upper     = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   int fail_count;
   int chars_pending;
   int numbers_done;
   int chars_done;

   int sender_idle_pct   = 32;
   int receiver_idle_pct = 83;
   int quiet_cycles      = 0;
   int signed_sent       = 0;
   int hex_sent          = 0;
   int wide_sent         = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   integer_to_ascii_digits i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_wide      (req_wide),
      .req_hex       (req_hex),
      .req_upper     (req_upper),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last)
   );

   integer_to_ascii_digits_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_wide      (req_wide),
      .req_hex       (req_hex),
      .req_upper     (req_upper),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .chars_pending (chars_pending),
      .numbers_done  (numbers_done),
      .chars_done    (chars_done)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // nothing accepted on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("** integer_to_ascii_digits: FAILED **");
         $finish;
      end
   end

   // Returns at the edge where the request is taken; valid stays up for a
   // back-to-back request
   task automatic send_number(input logic [63:0] value, input logic is_signed,
                              input logic wide, input logic hex, input logic upper);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_is_signed <= is_signed;
      req_wide      <= wide;
      req_hex       <= hex;
      req_upper     <= upper;
      signed_sent += is_signed;
      hex_sent    += hex;
      wide_sent   += wide;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int          sender_pct_by_phase[3];
      int          receiver_pct_by_phase[3];
      logic [63:0] operand;
      sender_pct_by_phase   = '{32, 83, 0};
      receiver_pct_by_phase = '{83, 32, 0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // zeros, single digits and digit rollovers
      send_number(64'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_number(64'd0, 1'b1, 1'b1, 1'b0, 1'b0);
      send_number(64'd0, 1'b0, 1'b1, 1'b1, 1'b1);
      send_number(64'd1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_number(64'd9, 1'b0, 1'b0, 1'b0, 1'b1);
      send_number(64'd10, 1'b0, 1'b0, 1'b0, 1'b0);
      send_number(64'h0F, 1'b0, 1'b0, 1'b1, 1'b0);
      send_number(64'h10, 1'b0, 1'b0, 1'b1, 1'b1);
      // narrow mode ignores the top half
      send_number(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
      send_number(64'h1234_5678_ABCD_EF01, 1'b0, 1'b0, 1'b1, 1'b1);
      send_number(64'h1234_5678_ABCD_EF01, 1'b0, 1'b0, 1'b1, 1'b0);
      // widest unsigned outputs
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1);
      send_number(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b1, 1'b0);
      send_number(64'h8AC7_2304_89E8_0000, 1'b0, 1'b1, 1'b0, 1'b0);
      // signed: most negative, minus one, most positive
      send_number(64'hFFFF_FFFF_8000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_number(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b0, 1'b0);
      send_number(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0);
      send_number(64'hFFFF_FFFF_7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0);
      // signed ignores hex and upper; bit 31 is no sign in wide mode
      send_number(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 1'b1, 1'b1, 1'b1);
      send_number(64'h0000_0000_8000_0000, 1'b1, 1'b1, 1'b1, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = sender_pct_by_phase[phase];
         receiver_idle_pct = receiver_pct_by_phase[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            case ($urandom_range(5))
               0: operand = {$urandom, $urandom};
               1: operand = 64'($urandom_range(99));
               2: operand = 64'd0 - 64'($urandom_range(1, 100));
               3: begin
                  // near a power of ten
                  operand = 64'd1;
                  repeat ($urandom_range(19)) operand = operand * 64'd10;
                  operand = operand + 64'($urandom_range(2)) - 64'd1;
               end
               4: operand = (64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1;
               default: operand = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            send_number(operand, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (chars_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d numbers: %0d signed, %0d with hex set, %0d in wide mode.",
               24 + 3 * RANDOM_PER_PHASE, signed_sent, hex_sent, wide_sent);
      $display("Checked %0d characters over %0d numbers under three idling mixes.",
               chars_done, numbers_done);
      if (fail_count == 0 && chars_pending == 0) begin
         $display("** integer_to_ascii_digits: PASSED **");
      end else begin
         $display("** integer_to_ascii_digits: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ia2d_pkg.sv
rtl/ia2d_bcd_step.sv
rtl/integer_to_ascii_digits.sv
sim/integer_to_ascii_digits_checker.sv
sim/tb.sv
